/* src/aabb_cr_pkg.sv */
// Shared types, widths and helper functions for the rectangle collision unit.
// No dependencies.
package aabb_cr_pkg;

  localparam int unsigned POS_W  = 14;  // ball / tile coordinate
  localparam int unsigned SIZE_W = 12;  // width / height
  localparam int unsigned VEL_W  = 11;  // velocity
  localparam int unsigned NEW_W  = 15;  // resolved coordinate
  localparam int unsigned CRD_W  = 16;  // internal signed working width

  typedef logic signed [CRD_W-1:0] crd_t;
  typedef logic signed [VEL_W-1:0] vel_t;
  typedef logic signed [NEW_W-1:0] npos_t;

  localparam vel_t VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};
  localparam vel_t VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};

  // One input item as held in the input register
  typedef struct packed {
    logic signed [POS_W-1:0] ball_x;
    logic signed [POS_W-1:0] ball_y;
    logic [SIZE_W-1:0]       ball_w;
    logic [SIZE_W-1:0]       ball_h;
    vel_t                    ball_vx;
    vel_t                    ball_vy;
    logic signed [POS_W-1:0] tile_x;
    logic signed [POS_W-1:0] tile_y;
    logic [SIZE_W-1:0]       tile_w;
    logic [SIZE_W-1:0]       tile_h;
    logic                    reflect_on;
  } item_t;

  // [a,b] lies within [c,d]
  function automatic logic span_in(crd_t a, crd_t b, crd_t c, crd_t d);
    span_in = (c <= a) && (b <= d);
  endfunction

  // Inclusive overlap length of [a,b] and [c,d]
  function automatic crd_t overlap_len(crd_t a, crd_t b, crd_t c, crd_t d);
    crd_t len;
    if ((b < c) || (d < a)) len = '0;
    else if (span_in(a, b, c, d)) len = d - c + crd_t'(1);
    else if (span_in(c, d, a, b)) len = b - a + crd_t'(1);
    else if (a <= c) len = b - c + crd_t'(1);
    else len = d - a + crd_t'(1);
    overlap_len = len;
  endfunction

  // Negation clamped to the velocity range
  function automatic vel_t neg_sat(vel_t v);
    neg_sat = (v == VEL_MIN) ? VEL_MAX : -v;
  endfunction

endpackage

/* src/aabb_collide_resolve_unit.sv */
// Top level of the rectangle collision check and push-out unit.
// Depends on aabb_cr_pkg.
//
// Usage:
// - Input channel (in_valid/in_ready): one moving rectangle (ball), one fixed
//   rectangle (tile) and a reflect flag per transfer.
// - Result channel (out_valid/out_ready): one result per input transfer, in
//   order: hit flag, resolved position and resolved velocity.
// - An input transfer passes the input register, then the result register,
//   before out_valid. One item per cycle while the receiver keeps out_ready
//   high, set by the single combinational pass between the two registers.
// - When the receiver stalls the two registers fill; in_ready drops only when
//   both hold an item and out_ready is low, so one item can still be taken
//   while a finished result waits.
// - Reset (rst_n low, synchronous) empties both stages; payload registers are
//   not cleared.
// - Resolution: on a hit the ball is moved along one axis just past the tile
//   edge on its side and, with reflect_on, that velocity is negated with
//   saturation. Containment on the chosen axis leaves the ball untouched.
module aabb_collide_resolve_unit
  import aabb_cr_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [POS_W-1:0] in_ball_x,
  input  logic signed [POS_W-1:0] in_ball_y,
  input  logic [SIZE_W-1:0]       in_ball_w,
  input  logic [SIZE_W-1:0]       in_ball_h,
  input  logic signed [VEL_W-1:0] in_ball_vx,
  input  logic signed [VEL_W-1:0] in_ball_vy,
  input  logic signed [POS_W-1:0] in_tile_x,
  input  logic signed [POS_W-1:0] in_tile_y,
  input  logic [SIZE_W-1:0]       in_tile_w,
  input  logic [SIZE_W-1:0]       in_tile_h,
  input  logic                    in_reflect_on,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_hit,
  output logic signed [NEW_W-1:0] out_new_x,
  output logic signed [NEW_W-1:0] out_new_y,
  output logic signed [VEL_W-1:0] out_new_vx,
  output logic signed [VEL_W-1:0] out_new_vy
);

  // Stage control
  logic  s1_valid_r, s1_valid_nxt;
  logic  out_valid_r, out_valid_nxt;
  logic  advance;
  logic  in_xfer;
  item_t s1_r;

  // Result register
  logic  hit_r, hit_nxt;
  npos_t nx_r, nx_nxt;
  npos_t ny_r, ny_nxt;
  vel_t  nvx_r, nvx_nxt;
  vel_t  nvy_r, nvy_nxt;

  // Working values
  crd_t a, b, c, d, e, f, g, h;
  crd_t bw, bh;
  crd_t ovl_x, ovl_y;
  logic x_contain, y_contain, along_y;

  // Result stage moves when empty or drained this cycle
  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || advance;
  assign in_xfer  = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = advance ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_r <= '{ball_x: in_ball_x, ball_y: in_ball_y, ball_w: in_ball_w,
                ball_h: in_ball_h, ball_vx: in_ball_vx, ball_vy: in_ball_vy,
                tile_x: in_tile_x, tile_y: in_tile_y, tile_w: in_tile_w,
                tile_h: in_tile_h, reflect_on: in_reflect_on};
    end
  end

  // Intervals: ball [a,b]x[e,f], tile [c,d]x[g,h]; zero size gives end = start-1
  always_comb begin
    bw = crd_t'({1'b0, s1_r.ball_w});
    bh = crd_t'({1'b0, s1_r.ball_h});
    a  = crd_t'(s1_r.ball_x);
    b  = a + bw - crd_t'(1);
    c  = crd_t'(s1_r.tile_x);
    d  = c + crd_t'({1'b0, s1_r.tile_w}) - crd_t'(1);
    e  = crd_t'(s1_r.ball_y);
    f  = e + bh - crd_t'(1);
    g  = crd_t'(s1_r.tile_y);
    h  = g + crd_t'({1'b0, s1_r.tile_h}) - crd_t'(1);
    ovl_x = overlap_len(a, b, c, d);
    ovl_y = overlap_len(e, f, g, h);
    x_contain = span_in(a, b, c, d) || span_in(c, d, a, b);
    y_contain = span_in(e, f, g, h) || span_in(g, h, e, f);
    // Axis choice: containment on x forces y, then containment on y forces x
    if (x_contain) along_y = 1'b1;
    else if (y_contain) along_y = 1'b0;
    else along_y = (ovl_y >= ovl_x);
  end

  // Push-out on the chosen axis
  always_comb begin
    hit_nxt = (ovl_x != '0) && (ovl_y != '0);
    nx_nxt  = npos_t'(a);
    ny_nxt  = npos_t'(e);
    nvx_nxt = s1_r.ball_vx;
    nvy_nxt = s1_r.ball_vy;
    if (hit_nxt) begin
      if (along_y) begin
        if (!y_contain) begin
          ny_nxt = (g <= e) ? npos_t'(h + crd_t'(1)) : npos_t'(g - bh);
          if (s1_r.reflect_on) nvy_nxt = neg_sat(s1_r.ball_vy);
        end
      end else begin
        if (!x_contain) begin
          nx_nxt = (c <= a) ? npos_t'(d + crd_t'(1)) : npos_t'(c - bw);
          if (s1_r.reflect_on) nvx_nxt = neg_sat(s1_r.ball_vx);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      hit_r <= hit_nxt;
      nx_r  <= nx_nxt;
      ny_r  <= ny_nxt;
      nvx_r <= nvx_nxt;
      nvy_r <= nvy_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_hit    = hit_r;
  assign out_new_x  = nx_r;
  assign out_new_y  = ny_r;
  assign out_new_vx = nvx_r;
  assign out_new_vy = nvy_r;

  // Input side stalls only when both stages are full and the receiver waits
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && out_valid_r && !out_ready))
    else $error("in_ready low without a full, stalled pipeline");

  // A held item reaches the result register on the next edge when it moves
  a_stage_move: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && advance) |=> out_valid_r)
    else $error("item lost between stages");

  // No hit leaves the ball position unchanged
  a_nohit_pos: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $past(s1_valid_r && advance) && !out_hit) |->
      (out_new_x == npos_t'($past(s1_r.ball_x)) &&
       out_new_y == npos_t'($past(s1_r.ball_y))))
    else $error("ball moved without a hit");

  // At most one axis is resolved per item
  a_one_axis: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $past(s1_valid_r && advance)) |->
      ((out_new_x == npos_t'($past(s1_r.ball_x)) &&
        out_new_vx == $past(s1_r.ball_vx)) ||
       (out_new_y == npos_t'($past(s1_r.ball_y)) &&
        out_new_vy == $past(s1_r.ball_vy))))
    else $error("both axes changed");

endmodule

/* verif/aabb_cr_checker.sv */
// Checker for the rectangle collision unit: watches both channels, predicts
// each result from the accepted input and compares it field by field.
// Depends on aabb_cr_pkg.
module aabb_cr_checker
  import aabb_cr_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic signed [POS_W-1:0] in_ball_x,
  input  logic signed [POS_W-1:0] in_ball_y,
  input  logic [SIZE_W-1:0]       in_ball_w,
  input  logic [SIZE_W-1:0]       in_ball_h,
  input  logic signed [VEL_W-1:0] in_ball_vx,
  input  logic signed [VEL_W-1:0] in_ball_vy,
  input  logic signed [POS_W-1:0] in_tile_x,
  input  logic signed [POS_W-1:0] in_tile_y,
  input  logic [SIZE_W-1:0]       in_tile_w,
  input  logic [SIZE_W-1:0]       in_tile_h,
  input  logic                    in_reflect_on,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic                    out_hit,
  input  logic signed [NEW_W-1:0] out_new_x,
  input  logic signed [NEW_W-1:0] out_new_y,
  input  logic signed [VEL_W-1:0] out_new_vx,
  input  logic signed [VEL_W-1:0] out_new_vy,
  output int                      fail_count,
  output int                      outstanding
);

  typedef struct packed {
    logic  hit;
    npos_t new_x;
    npos_t new_y;
    vel_t  new_vx;
    vel_t  new_vy;
  } collide_res_t;

  collide_res_t resolved_q[$];
  collide_res_t want;
  item_t        seen;
  int           misses = 0;
  int           backlog = 0;

  assign fail_count  = misses;
  assign outstanding = backlog;

  task automatic note_mismatch(input string what, input int got, input int wanted);
    $display("mismatch on %s: got %0d, wanted %0d (t=%0t)", what, got, wanted, $realtime);
    misses++;
  endtask

  // [a,b] sits within [c,d]
  function automatic bit holds(input int a, input int b, input int c, input int d);
    return (c <= a) && (b <= d);
  endfunction

  // inclusive overlap length; tile tested as container first
  function automatic int shared_len(input int a, input int b, input int c, input int d);
    if ((b < c) || (d < a)) return 0;
    if (holds(a, b, c, d)) return d - c + 1;
    if (holds(c, d, a, b)) return b - a + 1;
    if (a <= c) return b - c + 1;
    return d - a + 1;
  endfunction

  function automatic int flip_speed(input int v);
    int n;
    n = -v;
    if (n > 1023) n = 1023;
    if (n < -1024) n = -1024;
    return n;
  endfunction

  // move the ball clear of [lo,hi] on one axis; no-op under containment
  function automatic void push_clear(inout int pos, inout int vel, input int ext,
                                     input int lo, input int hi, input bit refl);
    int p1;
    p1 = pos + ext - 1;
    if (((lo <= pos) && (p1 <= hi)) || ((pos <= lo) && (hi <= p1))) return;
    pos = (lo <= pos) ? hi + 1 : lo - ext;
    if (refl) vel = flip_speed(vel);
  endfunction

  function automatic collide_res_t resolve_collision(input item_t it);
    collide_res_t r;
    int bx, by, bw, bh, vx, vy, tx, ty, tw, th;
    int u, v;
    bit along_y;
    bx = it.ball_x;  by = it.ball_y;
    bw = it.ball_w;  bh = it.ball_h;
    vx = it.ball_vx; vy = it.ball_vy;
    tx = it.tile_x;  ty = it.tile_y;
    tw = it.tile_w;  th = it.tile_h;
    u = shared_len(bx, bx + bw - 1, tx, tx + tw - 1);
    v = shared_len(by, by + bh - 1, ty, ty + th - 1);
    r.hit = (u != 0) && (v != 0);
    if (r.hit) begin
      if (holds(bx, bx + bw - 1, tx, tx + tw - 1) || holds(tx, tx + tw - 1, bx, bx + bw - 1))
        along_y = 1'b1;
      else if (holds(by, by + bh - 1, ty, ty + th - 1) ||
               holds(ty, ty + th - 1, by, by + bh - 1))
        along_y = 1'b0;
      else
        along_y = (v >= u);
      if (along_y) push_clear(by, vy, bh, ty, ty + th - 1, it.reflect_on);
      else push_clear(bx, vx, bw, tx, tx + tw - 1, it.reflect_on);
    end
    r.new_x  = NEW_W'(bx);
    r.new_y  = NEW_W'(by);
    r.new_vx = VEL_W'(vx);
    r.new_vy = VEL_W'(vy);
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      resolved_q.delete();
      backlog <= 0;
    end else begin
      if (in_valid && in_ready) begin
        seen.ball_x     = in_ball_x;
        seen.ball_y     = in_ball_y;
        seen.ball_w     = in_ball_w;
        seen.ball_h     = in_ball_h;
        seen.ball_vx    = in_ball_vx;
        seen.ball_vy    = in_ball_vy;
        seen.tile_x     = in_tile_x;
        seen.tile_y     = in_tile_y;
        seen.tile_w     = in_tile_w;
        seen.tile_h     = in_tile_h;
        seen.reflect_on = in_reflect_on;
        resolved_q.push_back(resolve_collision(seen));
      end
      if (out_valid && out_ready) begin
        if (resolved_q.size() == 0) begin
          note_mismatch("unrequested result, hit", int'(out_hit), -1);
        end else begin
          want = resolved_q.pop_front();
          if (out_hit !== want.hit) note_mismatch("hit", int'(out_hit), int'(want.hit));
          if (out_new_x !== want.new_x)
            note_mismatch("new_x", int'(out_new_x), int'(want.new_x));
          if (out_new_y !== want.new_y)
            note_mismatch("new_y", int'(out_new_y), int'(want.new_y));
          if (out_new_vx !== want.new_vx)
            note_mismatch("new_vx", int'(out_new_vx), int'(want.new_vx));
          if (out_new_vy !== want.new_vy)
            note_mismatch("new_vy", int'(out_new_vy), int'(want.new_vy));
        end
      end
      backlog <= resolved_q.size();
    end
  end

endmodule

/* verif/tb.sv */
// Testbench top for aabb_collide_resolve_unit: clock, reset, stimulus,
// receiver back-pressure, watchdog and verdict.
// Depends on aabb_cr_pkg, the unit itself and aabb_cr_checker.
module tb;
  import aabb_cr_pkg::*;

  // cycles without any transfer before the run is declared hung
  localparam int STALL_LIMIT = 2000;
  // settle time after the last result
  localparam int TAIL_CYCLES = 8;
  localparam int RANDOM_PAIRS = 1600;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  logic signed [POS_W-1:0] in_ball_x;
  logic signed [POS_W-1:0] in_ball_y;
  logic [SIZE_W-1:0]       in_ball_w;
  logic [SIZE_W-1:0]       in_ball_h;
  logic signed [VEL_W-1:0] in_ball_vx;
  logic signed [VEL_W-1:0] in_ball_vy;
  logic signed [POS_W-1:0] in_tile_x;
  logic signed [POS_W-1:0] in_tile_y;
  logic [SIZE_W-1:0]       in_tile_w;
  logic [SIZE_W-1:0]       in_tile_h;
  logic                    in_reflect_on;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic                    out_hit;
  logic signed [NEW_W-1:0] out_new_x;
  logic signed [NEW_W-1:0] out_new_y;
  logic signed [VEL_W-1:0] out_new_vx;
  logic signed [VEL_W-1:0] out_new_vy;
  int                      fail_count;
  int                      outstanding;

  // set during the steady stretch: no idling on either side
  bit calm = 1'b0;
  int quiet_cycles = 0;

  aabb_collide_resolve_unit i_dut (.*);
  aabb_cr_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver: stalls in roughly a third of cycles, never while calm.
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 34);
  end

  // Watchdog: any transfer on either channel resets the count.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one pair and hold it until the transfer. Random idle cycles go
  // in front, so gaps land in every phase of the pipeline. in_valid gets
  // at most one assignment per time step.
  task automatic push_item(input item_t it);
    while (!calm && ($urandom_range(99) < 34)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_ball_x     <= it.ball_x;
    in_ball_y     <= it.ball_y;
    in_ball_w     <= it.ball_w;
    in_ball_h     <= it.ball_h;
    in_ball_vx    <= it.ball_vx;
    in_ball_vy    <= it.ball_vy;
    in_tile_x     <= it.tile_x;
    in_tile_y     <= it.tile_y;
    in_tile_w     <= it.tile_w;
    in_tile_h     <= it.tile_h;
    in_reflect_on <= it.reflect_on;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic put_pair(input int bx, input int by, input int bw, input int bh,
                          input int vx, input int vy, input int tx, input int ty,
                          input int tw, input int th, input bit refl);
    item_t it;
    it.ball_x     = POS_W'(bx);
    it.ball_y     = POS_W'(by);
    it.ball_w     = SIZE_W'(bw);
    it.ball_h     = SIZE_W'(bh);
    it.ball_vx    = VEL_W'(vx);
    it.ball_vy    = VEL_W'(vy);
    it.tile_x     = POS_W'(tx);
    it.tile_y     = POS_W'(ty);
    it.tile_w     = SIZE_W'(tw);
    it.tile_h     = SIZE_W'(th);
    it.reflect_on = refl;
    push_item(it);
  endtask

  // Sender holds off until every predicted result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // mostly small extents, some large, a few zero
  function automatic int pick_extent();
    int r;
    r = $urandom_range(99);
    if (r < 3) return 0;
    if (r < 10) return $urandom_range(4095, 1);
    return $urandom_range(48, 1);
  endfunction

  function automatic vel_t pick_speed();
    vel_t v;
    v = VEL_W'($urandom);
    if ($urandom_range(7) == 0) v = $urandom_range(1) ? VEL_MIN : VEL_MAX;
    return v;
  endfunction

  // Most pairs are placed close enough to touch or overlap; the rest are
  // raw noise over every field bit.
  function automatic item_t roll_pair();
    item_t it;
    int bw, bh, tw, th, tx, ty;
    if ($urandom_range(99) < 15) begin
      it.ball_x  = POS_W'($urandom);
      it.ball_y  = POS_W'($urandom);
      it.ball_w  = SIZE_W'($urandom);
      it.ball_h  = SIZE_W'($urandom);
      it.ball_vx = VEL_W'($urandom);
      it.ball_vy = VEL_W'($urandom);
      it.tile_x  = POS_W'($urandom);
      it.tile_y  = POS_W'($urandom);
      it.tile_w  = SIZE_W'($urandom);
      it.tile_h  = SIZE_W'($urandom);
    end else begin
      bw = pick_extent();
      bh = pick_extent();
      tw = pick_extent();
      th = pick_extent();
      tx = int'($urandom_range(16383)) - 8192;
      ty = int'($urandom_range(16383)) - 8192;
      it.tile_x  = POS_W'(tx);
      it.tile_y  = POS_W'(ty);
      it.tile_w  = SIZE_W'(tw);
      it.tile_h  = SIZE_W'(th);
      it.ball_w  = SIZE_W'(bw);
      it.ball_h  = SIZE_W'(bh);
      it.ball_x  = POS_W'(tx + int'($urandom_range(tw + bw + 8)) - bw - 4);
      it.ball_y  = POS_W'(ty + int'($urandom_range(th + bh + 8)) - bh - 4);
      it.ball_vx = pick_speed();
      it.ball_vy = pick_speed();
    end
    it.reflect_on = 1'($urandom_range(1));
    return it;
  endfunction

  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_ball_x     <= '0;
    in_ball_y     <= '0;
    in_ball_w     <= '0;
    in_ball_h     <= '0;
    in_ball_vx    <= '0;
    in_ball_vy    <= '0;
    in_tile_x     <= '0;
    in_tile_y     <= '0;
    in_tile_w     <= '0;
    in_tile_h     <= '0;
    in_reflect_on <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed pairs: ball x, y, w, h, vx, vy, then tile x, y, w, h, reflect.
    put_pair(0, 0, 10, 10, 5, 5, 20, 0, 10, 10, 1);          // apart on x
    put_pair(0, 0, 10, 10, 5, 5, 0, 20, 10, 10, 1);          // apart on y
    put_pair(0, 0, 10, 10, 5, 5, 10, 0, 10, 10, 1);          // edges just adjacent
    put_pair(2, 0, 4, 10, 3, 7, 0, 5, 10, 10, 1);            // x nested, ball above
    put_pair(2, 10, 4, 10, 3, 7, 0, 5, 10, 10, 1);           // x nested, ball below
    put_pair(0, 2, 10, 4, 7, 3, 5, 0, 10, 10, 1);            // y nested, push left
    put_pair(10, 2, 10, 4, 7, 3, 5, 0, 10, 10, 1);           // y nested, push right
    put_pair(0, 0, 10, 10, 4, -4, 7, 5, 10, 10, 1);          // corner, y overlap larger
    put_pair(0, 0, 10, 10, 4, -4, 3, 7, 10, 10, 1);          // corner, x overlap larger
    put_pair(0, 0, 10, 10, 4, -4, 5, 5, 10, 10, 1);          // equal overlaps
    put_pair(2, 2, 4, 4, 9, 9, 0, 0, 10, 10, 1);             // ball inside tile
    put_pair(0, 0, 10, 10, 9, 9, 2, 2, 4, 4, 1);             // tile inside ball
    put_pair(0, 0, 10, 10, 4, -4, 7, 5, 10, 10, 0);          // no reflection
    put_pair(2, 0, 4, 10, 3, -1024, 0, 5, 10, 10, 1);        // negate lowest vy
    put_pair(0, 2, 10, 4, -1024, 1023, 5, 0, 10, 10, 1);     // negate lowest vx
    put_pair(0, 2, 10, 4, 1023, -1024, 5, 0, 10, 10, 1);     // negate highest vx
    put_pair(-8192, -8192, 4095, 4095, 1023, -1024, -8000, -8190, 4095, 4095, 1);
    put_pair(8191, 8191, 4095, 4095, -1024, 1023, 8000, 8100, 4095, 4095, 1);
    put_pair(8191, 0, 4095, 10, 1, 1, 8191, 5, 1, 10, 1);    // far edge, x nested
    put_pair(5, 0, 0, 10, 1, 1, 0, 0, 10, 10, 1);            // zero-width ball
    put_pair(0, 0, 10, 10, 1, 1, 0, 5, 10, 0, 1);            // zero-height tile
    put_pair(8191, 8191, 4095, 4095, 1023, 1023, 8191, 8191, 4095, 4095, 1);
    put_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);               // everything zero
    drain_results();

    // Random part; a steady stretch with no idling in the middle and a few
    // full drains along the way.
    for (int n = 0; n < RANDOM_PAIRS; n++) begin
      calm = (n >= 700) && (n < 1000);
      push_item(roll_pair());
      if ((n % 400) == 399) drain_results();
    end
    calm = 1'b0;

    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* files.f */
src/aabb_cr_pkg.sv
src/aabb_collide_resolve_unit.sv
verif/aabb_cr_checker.sv
verif/tb.sv
